FILE: rtl/core/svv_pkg.sv
package svv_pkg;

  localparam int MaxLen   = 256;
  localparam int PosLimit = (MaxLen < 256) ? MaxLen : 256;
  localparam int PosW     = 8;
  localparam int NumW     = 63;
  localparam int FifoDepth = 2;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

  // parser phases
  localparam logic [3:0] PhMajFirst = 4'd0;
  localparam logic [3:0] PhMajMore  = 4'd1;
  localparam logic [3:0] PhMajZero  = 4'd2;
  localparam logic [3:0] PhMinFirst = 4'd3;
  localparam logic [3:0] PhMinMore  = 4'd4;
  localparam logic [3:0] PhMinZero  = 4'd5;
  localparam logic [3:0] PhPatFirst = 4'd6;
  localparam logic [3:0] PhPatMore  = 4'd7;
  localparam logic [3:0] PhPatZero  = 4'd8;
  localparam logic [3:0] PhPreFirst = 4'd9;
  localparam logic [3:0] PhPreIn    = 4'd10;
  localparam logic [3:0] PhBldFirst = 4'd11;
  localparam logic [3:0] PhBldIn    = 4'd12;

  // identifier flag bits
  localparam int FlagNum   = 0;
  localparam int FlagZero  = 1;
  localparam int FlagMulti = 2;
  localparam logic [2:0] FlagsBadPre = 3'b111;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  // packed first member lands in the top bits
  typedef struct packed {
    logic            too_long;
    logic [PosW-1:0] prerelease_len;
    logic [PosW-1:0] prerelease_start;
    logic            has_prerelease;
    logic [NumW-1:0] patch;
    logic [NumW-1:0] minor;
    logic [NumW-1:0] major;
    logic            valid_res;
  } res_t;

  localparam int ResW = $bits(res_t);

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    is_ident = is_dig(c) || ((c >= ChLoA) && (c <= ChLoZ)) ||
               ((c >= ChUpA) && (c <= ChUpZ)) || (c == ChDash);
  endfunction

endpackage

FILE: rtl/core/semver_string_validator_core.sv
// Strict SemVer 2.0.0 syntax checker on a byte stream. One character of the
// version string is taken per transfer on the slave side, with tlast on the
// final character; one result transfer leaves on the master side for each
// string, right after its final character, none for the others. The block
// takes one character every cycle while the result buffer has room: each
// character passes an input register and the parse logic (the widest part
// is the 63-bit times-ten add with its overflow check) and, for the final
// character, a two-entry result buffer, from which its result is offered.
// A final character waits in the input register only while both buffer
// entries are full; other characters never wait. Numbers are limited to
// 2^63-1, at most 256 characters are
// parsed per string (longer strings raise too_long and report invalid), any
// syntax fault sticks until the final character, and all numeric and
// prerelease fields read zero on an invalid string. The build part is checked
// and then dropped. No clearing pass after reset.
module semver_string_validator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave side: one string character per transfer
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] ch
  input  logic                      s_axis_tlast,   // final character of the string
  // master side: one result per string
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] valid_res, [63:1] major, [126:64] minor, [189:127] patch,
  // [190] has_prerelease, [198:191] prerelease_start,
  // [206:199] prerelease_len, [207] too_long
  output logic [svv_pkg::ResW-1:0]  m_axis_tdata
);

  logic          in_v_q;
  logic [7:0]    ch_q;
  logic          last_q;
  logic          advance;
  logic          fifo_space;
  logic          res_valid;
  svv_pkg::res_t res;
  svv_pkg::res_t out_res;

  // a final character may only advance when the result buffer has room;
  // other characters never wait
  assign advance       = in_v_q & (~last_q | fifo_space);
  assign s_axis_tready = ~in_v_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ch_q   <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  svv_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .ch_i        (ch_q),
    .last_i      (last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  svv_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (fifo_space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule

FILE: rtl/core/svv_parse.sv
module svv_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           ch_i,
  input  logic                 last_i,
  output logic                 res_valid_o,
  output svv_pkg::res_t        res_o
);

  logic [3:0]                    phase_q, phase_d;
  logic [svv_pkg::NumW-1:0]      acc_q, acc_d;
  logic [svv_pkg::NumW-1:0]      maj_q, maj_d;
  logic [svv_pkg::NumW-1:0]      min_q, min_d;
  logic [2:0]                    flags_q, flags_d;
  logic [svv_pkg::PosW-1:0]      pos_q, pos_d;
  logic [svv_pkg::PosW-1:0]      pre_begin_q, pre_begin_d;
  logic [svv_pkg::PosW-1:0]      pre_count_q, pre_count_d;
  logic                          err_q, err_d;
  logic                          overlong_q, overlong_d;

  logic                          dig, ident, fault, ok;
  logic [svv_pkg::NumW+3:0]      mul;
  logic                          ovf;
  logic [svv_pkg::PosW:0]        pos_inc;
  svv_pkg::res_t                 res;

  assign dig     = svv_pkg::is_dig(ch_i);
  assign ident   = svv_pkg::is_ident(ch_i);
  // acc*10 + digit, overflow when it passes 2^63-1
  assign mul     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                   {{(svv_pkg::NumW){1'b0}}, ch_i[3:0]};
  assign ovf     = |mul[svv_pkg::NumW+3:svv_pkg::NumW];
  assign pos_inc = {1'b0, pos_q} + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    maj_d       = maj_q;
    min_d       = min_q;
    flags_d     = flags_q;
    pre_begin_d = pre_begin_q;
    pre_count_d = pre_count_q;
    fault       = 1'b0;
    case (phase_q)
      svv_pkg::PhMajFirst, svv_pkg::PhMinFirst, svv_pkg::PhPatFirst: begin
        if (!dig) begin
          fault = 1'b1;
        end else begin
          acc_d   = {{(svv_pkg::NumW-4){1'b0}}, ch_i[3:0]};
          phase_d = (ch_i == svv_pkg::ChZero) ? phase_q + 4'd2 : phase_q + 4'd1;
        end
      end
      svv_pkg::PhMajMore, svv_pkg::PhMinMore,
      svv_pkg::PhMajZero, svv_pkg::PhMinZero: begin
        if (dig && (phase_q == svv_pkg::PhMajMore || phase_q == svv_pkg::PhMinMore)) begin
          if (ovf) fault = 1'b1;
          else acc_d = mul[svv_pkg::NumW-1:0];
        end else if (ch_i != svv_pkg::ChDot) begin
          fault = 1'b1;
        end else begin
          if (phase_q == svv_pkg::PhMajMore || phase_q == svv_pkg::PhMajZero) begin
            maj_d   = acc_q;
            phase_d = svv_pkg::PhMinFirst;
          end else begin
            min_d   = acc_q;
            phase_d = svv_pkg::PhPatFirst;
          end
          acc_d = '0;
        end
      end
      svv_pkg::PhPatMore, svv_pkg::PhPatZero: begin
        if (dig && phase_q == svv_pkg::PhPatMore) begin
          if (ovf) fault = 1'b1;
          else acc_d = mul[svv_pkg::NumW-1:0];
        end else if (ch_i == svv_pkg::ChDash) begin
          pre_begin_d = pos_inc[svv_pkg::PosW-1:0];
          pre_count_d = '0;
          phase_d     = svv_pkg::PhPreFirst;
        end else if (ch_i == svv_pkg::ChPlus) begin
          phase_d = svv_pkg::PhBldFirst;
        end else begin
          fault = 1'b1;
        end
      end
      svv_pkg::PhPreFirst, svv_pkg::PhBldFirst: begin
        if (!ident) begin
          fault = 1'b1;
        end else begin
          flags_d = {1'b0, ch_i == svv_pkg::ChZero, dig};
          if (phase_q == svv_pkg::PhPreFirst) begin
            phase_d     = svv_pkg::PhPreIn;
            pre_count_d = pre_count_q + 1'b1;
          end else begin
            phase_d = svv_pkg::PhBldIn;
          end
        end
      end
      svv_pkg::PhPreIn: begin
        if (ident) begin
          flags_d[svv_pkg::FlagMulti] = 1'b1;
          flags_d[svv_pkg::FlagNum]   = flags_q[svv_pkg::FlagNum] & dig;
          pre_count_d = pre_count_q + 1'b1;
        end else if (flags_q == svv_pkg::FlagsBadPre) begin
          fault = 1'b1;   // numeric identifier with a leading zero
        end else if (ch_i == svv_pkg::ChDot) begin
          phase_d     = svv_pkg::PhPreFirst;
          pre_count_d = pre_count_q + 1'b1;
        end else if (ch_i == svv_pkg::ChPlus) begin
          phase_d = svv_pkg::PhBldFirst;
        end else begin
          fault = 1'b1;
        end
      end
      svv_pkg::PhBldIn: begin
        if (ident) begin
          flags_d[svv_pkg::FlagMulti] = 1'b1;
          flags_d[svv_pkg::FlagNum]   = flags_q[svv_pkg::FlagNum] & dig;
        end else if (ch_i == svv_pkg::ChDot) begin
          phase_d = svv_pkg::PhBldFirst;
        end else begin
          fault = 1'b1;
        end
      end
      default: fault = 1'b1;
    endcase
    // sticky error and overlong freeze the parse
    if (err_q || overlong_q) begin
      phase_d     = phase_q;
      acc_d       = acc_q;
      maj_d       = maj_q;
      min_d       = min_q;
      flags_d     = flags_q;
      pre_begin_d = pre_begin_q;
      pre_count_d = pre_count_q;
      fault       = 1'b0;
    end
  end

  always_comb begin
    err_d      = err_q | fault;
    overlong_d = overlong_q;
    pos_d      = pos_q;
    if (!last_i) begin
      if ({1'b0, pos_inc} >= svv_pkg::PosLimit[svv_pkg::PosW+1:0]) overlong_d = 1'b1;
      else pos_d = pos_inc[svv_pkg::PosW-1:0];
    end
  end

  always_comb begin
    ok = !err_d && !overlong_q;
    if (phase_d == svv_pkg::PhPreIn) begin
      ok = ok && (flags_d != svv_pkg::FlagsBadPre);
    end else begin
      ok = ok && (phase_d == svv_pkg::PhPatMore || phase_d == svv_pkg::PhPatZero ||
                  phase_d == svv_pkg::PhBldIn);
    end
    res                  = '0;
    res.too_long         = overlong_q;
    if (ok) begin
      res.valid_res = 1'b1;
      res.major     = maj_d;
      res.minor     = min_d;
      res.patch     = acc_d;
      if (pre_begin_d != '0) begin
        res.has_prerelease   = 1'b1;
        res.prerelease_start = pre_begin_d;
        res.prerelease_len   = pre_count_d;
      end
    end
  end

  assign res_valid_o = step_i & last_i;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= svv_pkg::PhMajFirst;
      acc_q       <= '0;
      maj_q       <= '0;
      min_q       <= '0;
      flags_q     <= '0;
      pos_q       <= '0;
      pre_begin_q <= '0;
      pre_count_q <= '0;
      err_q       <= 1'b0;
      overlong_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q     <= svv_pkg::PhMajFirst;
        acc_q       <= '0;
        maj_q       <= '0;
        min_q       <= '0;
        flags_q     <= '0;
        pos_q       <= '0;
        pre_begin_q <= '0;
        pre_count_q <= '0;
        err_q       <= 1'b0;
        overlong_q  <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        acc_q       <= acc_d;
        maj_q       <= maj_d;
        min_q       <= min_d;
        flags_q     <= flags_d;
        pos_q       <= pos_d;
        pre_begin_q <= pre_begin_d;
        pre_count_q <= pre_count_d;
        err_q       <= err_d;
        overlong_q  <= overlong_d;
      end
    end
  end

endmodule

FILE: rtl/core/svv_out_fifo.sv
module svv_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  svv_pkg::res_t             data_i,
  output logic                      space_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output svv_pkg::res_t             data_o
);

  svv_pkg::res_t                     mem_q [svv_pkg::FifoDepth];
  logic [svv_pkg::FifoCntW-1:0]      cnt_q;
  logic [svv_pkg::FifoPtrW-1:0]      wr_q, rd_q;
  logic                              pop;

  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q != svv_pkg::FifoDepth[svv_pkg::FifoCntW-1:0]);
  assign pop     = valid_o & ready_i;
  assign data_o  = mem_q[rd_q];

  function automatic logic [svv_pkg::FifoPtrW-1:0] ptr_next(
      input logic [svv_pkg::FifoPtrW-1:0] p);
    ptr_next = (p == svv_pkg::FifoPtrW'(svv_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      if (push_i) wr_q <= ptr_next(wr_q);
      if (pop) rd_q <= ptr_next(rd_q);
      if (push_i && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: rtl/core/svv_checker.sv
module svv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [svv_pkg::ResW-1:0]  m_axis_tdata
);

  svv_pkg::res_t r;
  assign r = m_axis_tdata;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // with no result waiting the input is never held off
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result buffer");

  // an invalid result carries no numbers and no prerelease
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !r.valid_res |->
      r.major == '0 && r.minor == '0 && r.patch == '0 &&
      !r.has_prerelease && r.prerelease_start == '0 && r.prerelease_len == '0)
    else $error("invalid result with nonzero fields");

  // a prerelease never starts at index zero and needs a valid string
  a_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.has_prerelease |->
      r.valid_res && r.prerelease_start != '0 && r.prerelease_len != '0)
    else $error("prerelease fields inconsistent");

  // an overlong string is never reported valid
  a_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.too_long |-> !r.valid_res)
    else $error("too_long result marked valid");

endmodule

bind semver_string_validator_core svv_checker u_svv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_semver_string_validator_core.sv
`timescale 1ns / 100ps

module tb_semver_string_validator_core;

  localparam int QuietLimit = 2000;  // cycles without any transfer before giving up
  localparam int HoldCycles = 300;   // long receiver hold-off to back up the input
  localparam int ItemTarget = 1900;  // characters to send in total

  // version parser mirror and queue of expected results
  class semver_scoreboard;
    logic [3:0]      phase;
    longint unsigned acc;
    longint unsigned major_q;
    longint unsigned minor_q;
    logic [2:0]      flags;
    int unsigned     pos;
    logic [7:0]      pre_begin;
    logic [7:0]      pre_count;
    bit              err;
    bit              overlong;
    svv_pkg::res_t   pending[$];
    int              errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase     = svv_pkg::PhMajFirst;
      acc       = 0;
      major_q   = 0;
      minor_q   = 0;
      flags     = '0;
      pos       = 0;
      pre_begin = '0;
      pre_count = '0;
      err       = 1'b0;
      overlong  = 1'b0;
    endfunction

    function bit digit_char(logic [7:0] c);
      return (c >= svv_pkg::ChZero) && (c <= svv_pkg::ChNine);
    endfunction

    function bit ident_char(logic [7:0] c);
      return digit_char(c) || ((c >= svv_pkg::ChLoA) && (c <= svv_pkg::ChLoZ)) ||
             ((c >= svv_pkg::ChUpA) && (c <= svv_pkg::ChUpZ)) || (c == svv_pkg::ChDash);
    endfunction

    // times ten plus digit, refused when past 2^63-1
    function bit add_digit(logic [7:0] c);
      longint unsigned d;
      d = longint'(c - svv_pkg::ChZero);
      if (acc > (64'h7FFF_FFFF_FFFF_FFFF - d) / 10) return 1'b0;
      acc = acc * 10 + d;
      return 1'b1;
    endfunction

    function void ident_begin(logic [7:0] c, logic [3:0] next);
      flags                    = '0;
      flags[svv_pkg::FlagNum]  = digit_char(c);
      flags[svv_pkg::FlagZero] = (c == svv_pkg::ChZero);
      phase                    = next;
    endfunction

    function void ident_grow(logic [7:0] c);
      flags[svv_pkg::FlagMulti] = 1'b1;
      if (!digit_char(c)) flags[svv_pkg::FlagNum] = 1'b0;
    endfunction

    // one grammar step, 0 on a syntax fault
    function bit parse_char(logic [7:0] c);
      case (phase)
        svv_pkg::PhMajFirst, svv_pkg::PhMinFirst, svv_pkg::PhPatFirst: begin
          if (!digit_char(c)) return 1'b0;
          acc   = longint'(c - svv_pkg::ChZero);
          phase = (c == svv_pkg::ChZero) ? phase + 4'd2 : phase + 4'd1;
          return 1'b1;
        end
        svv_pkg::PhMajMore, svv_pkg::PhMinMore,
        svv_pkg::PhMajZero, svv_pkg::PhMinZero: begin
          if ((phase == svv_pkg::PhMajMore || phase == svv_pkg::PhMinMore) &&
              digit_char(c))
            return add_digit(c);
          if (c != svv_pkg::ChDot) return 1'b0;
          if (phase <= svv_pkg::PhMajZero) begin
            major_q = acc;
            phase   = svv_pkg::PhMinFirst;
          end else begin
            minor_q = acc;
            phase   = svv_pkg::PhPatFirst;
          end
          acc = 0;
          return 1'b1;
        end
        svv_pkg::PhPatMore, svv_pkg::PhPatZero: begin
          if (phase == svv_pkg::PhPatMore && digit_char(c)) return add_digit(c);
          if (c == svv_pkg::ChDash) begin
            pre_begin = 8'(pos + 1);
            pre_count = '0;
            phase     = svv_pkg::PhPreFirst;
            return 1'b1;
          end
          if (c == svv_pkg::ChPlus) begin
            phase = svv_pkg::PhBldFirst;
            return 1'b1;
          end
          return 1'b0;
        end
        svv_pkg::PhPreFirst: begin
          if (!ident_char(c)) return 1'b0;
          ident_begin(c, svv_pkg::PhPreIn);
          pre_count = pre_count + 8'd1;
          return 1'b1;
        end
        svv_pkg::PhPreIn: begin
          if (ident_char(c)) begin
            ident_grow(c);
            pre_count = pre_count + 8'd1;
            return 1'b1;
          end
          // numeric identifier with a leading zero ends here
          if (flags == svv_pkg::FlagsBadPre) return 1'b0;
          if (c == svv_pkg::ChDot) begin
            phase     = svv_pkg::PhPreFirst;
            pre_count = pre_count + 8'd1;
            return 1'b1;
          end
          if (c == svv_pkg::ChPlus) begin
            phase = svv_pkg::PhBldFirst;
            return 1'b1;
          end
          return 1'b0;
        end
        svv_pkg::PhBldFirst: begin
          if (!ident_char(c)) return 1'b0;
          ident_begin(c, svv_pkg::PhBldIn);
          return 1'b1;
        end
        svv_pkg::PhBldIn: begin
          if (ident_char(c)) begin
            ident_grow(c);
            return 1'b1;
          end
          if (c == svv_pkg::ChDot) begin
            phase = svv_pkg::PhBldFirst;
            return 1'b1;
          end
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    // accepted input character
    function void take_char(logic [7:0] c, logic l);
      bit            ok;
      svv_pkg::res_t want;
      if (!err && !overlong && !parse_char(c)) err = 1'b1;
      if (!l) begin
        // position saturates at the limit
        if (pos + 1 >= svv_pkg::PosLimit) overlong = 1'b1;
        else pos++;
        return;
      end
      ok = !err && !overlong;
      if (ok) begin
        if (phase == svv_pkg::PhPreIn) ok = (flags != svv_pkg::FlagsBadPre);
        else ok = (phase == svv_pkg::PhPatMore) || (phase == svv_pkg::PhPatZero) ||
                  (phase == svv_pkg::PhBldIn);
      end
      want = '0;
      if (ok) begin
        want.valid_res = 1'b1;
        want.major     = major_q[svv_pkg::NumW-1:0];
        want.minor     = minor_q[svv_pkg::NumW-1:0];
        want.patch     = acc[svv_pkg::NumW-1:0];
        if (pre_begin != '0) begin
          want.has_prerelease   = 1'b1;
          want.prerelease_start = pre_begin;
          want.prerelease_len   = pre_count;
        end
      end
      want.too_long = overlong;
      pending.push_back(want);
      clear();
    endfunction

    function void note_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // accepted result transfer
    function void check_result(svv_pkg::res_t got);
      svv_pkg::res_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no string pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      note_field("valid_res",        64'(want.valid_res),        64'(got.valid_res));
      note_field("major",            64'(want.major),            64'(got.major));
      note_field("minor",            64'(want.minor),            64'(got.minor));
      note_field("patch",            64'(want.patch),            64'(got.patch));
      note_field("has_prerelease",   64'(want.has_prerelease),   64'(got.has_prerelease));
      note_field("prerelease_start", 64'(want.prerelease_start), 64'(got.prerelease_start));
      note_field("prerelease_len",   64'(want.prerelease_len),   64'(got.prerelease_len));
      note_field("too_long",         64'(want.too_long),         64'(got.too_long));
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;   // [7:0] ch
  logic                      s_axis_tlast = 1'b0; // final character of the string
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [svv_pkg::ResW-1:0]  m_axis_tdata;        // res_t, valid_res at bit 0 up to too_long

  semver_scoreboard  sb;
  logic [7:0]        str_q[$];            // characters of the string being built
  string             ident_chars = {"0123456789abcdefghijklmnopqrstuvwxyz",
                                    "ABCDEFGHIJKLMNOPQRSTUVWXYZ-"};
  string             odd_chars = ".-+0";
  bit                calm = 1'b0;         // no idling on either side
  bit                hold_off_req = 1'b0; // asks the receiver for one long hold-off
  int                quiet_cycles = 0;
  int                sent_chars = 0;      // characters handed to the driver so far

  semver_string_validator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // transfer monitor, scoreboard updates and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(svv_pkg::res_t'(m_axis_tdata));
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic l);
    while (!calm && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_string();
    if (str_q.size() == 0) str_q.push_back(8'($urandom_range(0, 255)));
    sent_chars += str_q.size();
    foreach (str_q[i]) send_char(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_digit();
    return svv_pkg::ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_ident();
    return ident_chars[$urandom_range(0, ident_chars.len() - 1)];
  endfunction

  // decimal part: zero, short, near the limit, past it, or a leading zero
  function automatic void put_num();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: str_q.push_back(svv_pkg::ChZero);
      2, 3, 4, 5: begin
        str_q.push_back(svv_pkg::ChZero + 8'($urandom_range(1, 9)));
        repeat ($urandom_range(0, 2)) str_q.push_back(pick_digit());
      end
      6: begin
        put_text("922337203685477580");
        str_q.push_back(pick_digit());
      end
      7: begin
        str_q.push_back(svv_pkg::ChZero + 8'($urandom_range(1, 9)));
        repeat (18) str_q.push_back(pick_digit());
      end
      8: begin
        str_q.push_back(svv_pkg::ChZero + 8'($urandom_range(1, 9)));
        repeat (19) str_q.push_back(pick_digit());
      end
      default: begin
        str_q.push_back(svv_pkg::ChZero);
        repeat ($urandom_range(1, 2)) str_q.push_back(pick_digit());
      end
    endcase
  endfunction

  function automatic void put_idents();
    int n;
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      if (k > 0) str_q.push_back(svv_pkg::ChDot);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) str_q.push_back(pick_digit());
      else
        repeat ($urandom_range(1, 6)) str_q.push_back(pick_ident());
    end
  endfunction

  // mostly well-formed versions, some damaged, some noise and overlong ones
  function automatic void make_random_string();
    int kind;
    int idx;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 10)) str_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 7) begin
      // around the position limit
      put_text("1.2.3-");
      repeat ($urandom_range(245, 255)) str_q.push_back(pick_ident());
    end else begin
      put_num();
      str_q.push_back(svv_pkg::ChDot);
      put_num();
      str_q.push_back(svv_pkg::ChDot);
      put_num();
      if ($urandom_range(0, 1)) begin
        str_q.push_back(svv_pkg::ChDash);
        put_idents();
      end
      if ($urandom_range(0, 2) == 0) begin
        str_q.push_back(svv_pkg::ChPlus);
        put_idents();
      end
      if ($urandom_range(0, 3) == 0) begin
        idx = $urandom_range(0, str_q.size() - 1);
        case ($urandom_range(0, 2))
          0: str_q[idx] = 8'($urandom_range(0, 255));
          1: while (str_q.size() > idx + 1) void'(str_q.pop_back());
          default: str_q[idx] = odd_chars[$urandom_range(0, 3)];
        endcase
      end
    end
  endfunction

  initial begin
    int n_str;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings: well-formed, leading zeros, limits, bad bytes, early ends
    put_text("0.0.0");                  send_string();
    put_text("10.20.30-alpha.1+build.5"); send_string();
    put_text("1.0.0-0A.is.legal");      send_string();
    put_text("1.0.0-0");                send_string();
    put_text("1.0.0-01");               send_string();
    put_text("1.0.0-rc.01+b");          send_string();
    put_text("1.0.0+001.x-y");          send_string();
    put_text("01.1.1");                 send_string();
    put_text("1.01.1");                 send_string();
    put_text("1.1.01");                 send_string();
    put_text("9223372036854775807.9223372036854775807.9223372036854775807");
    send_string();
    put_text("9223372036854775808.0.0"); send_string();
    put_text("1.");                     send_string();
    put_text("1.2");                    send_string();
    put_text("1.2.3-");                 send_string();
    put_text("1.2.3+");                 send_string();
    put_text("1.2.3-a.");               send_string();
    put_text("1.2.3-a..b");             send_string();
    put_text("1.2.3-x-y--z.0+--.1");    send_string();
    put_text("1.2"); str_q.push_back(8'h00); put_text(".3"); send_string();
    put_text("1.2.3"); str_q.push_back(8'hFF); send_string();
    // exactly at the position limit, then one past it
    put_text("1.2.3-"); repeat (250) str_q.push_back(pick_ident()); send_string();
    put_text("1.2.3-"); repeat (251) str_q.push_back(8'h61); send_string();

    n_str = 0;
    while (sent_chars < ItemTarget) begin
      if (n_str == 5) hold_off_req = 1'b1;
      calm = (n_str >= 15) && (n_str < 30);
      make_random_string();
      send_string();
      n_str++;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // let the monitor record the final transfer before draining
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: semver_string_validator_core.f
rtl/core/svv_pkg.sv
rtl/core/svv_parse.sv
rtl/core/svv_out_fifo.sv
rtl/core/semver_string_validator_core.sv
rtl/core/svv_checker.sv
sim/tb_semver_string_validator_core.sv
